[design/rbsl_pkg.sv]
package rbsl_pkg;

   // Configuration register indexes.
   localparam logic [1:0] CSR_MAX_RPM    = 2'd0;
   localparam logic [1:0] CSR_SHIFT_RPM  = 2'd1;
   localparam logic [1:0] CSR_TIMEOUT_MS = 2'd2;

   localparam logic [15:0] MAX_RPM_RESET    = 16'd8000;
   localparam logic [15:0] SHIFT_RPM_RESET  = 16'd7000;
   localparam logic [15:0] TIMEOUT_MS_RESET = 16'd5000;

   // Result pattern codes.
   localparam logic [1:0] PAT_OFF = 2'd0;
   localparam logic [1:0] PAT_BAR = 2'd1;
   localparam logic [1:0] PAT_RED = 2'd2;

   localparam logic [4:0]  FULL_BAR = 5'd16;
   localparam logic [15:0] BLINK_MS = 16'd100;

   // The time compare walks the 32-bit stamps one nibble per cycle.
   localparam int DIGIT_W  = 4;
   localparam int TIME_W   = 32;
   localparam int DIGITS   = TIME_W / DIGIT_W;
   localparam int DIGIT_CW = $clog2(DIGITS);

   // Quotient bits left after the saturation check (bar below sixteen).
   localparam int QUOT_W = 4;
   localparam int QUOT_CW = $clog2(QUOT_W);

   typedef struct packed {
      logic blink_due;
      logic idle_due;
   } rbsl_tchk_type;

endpackage

[design/rpm_bargraph_shift_light_top.sv]
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_ready  req_rpm[15:0], req_now_ms[31:0]
// rsp_      out        rsp_valid/rsp_ready  rsp_refresh, rsp_pattern[1:0], rsp_bar_count[4:0]
// csr_      in         csr_we               csr_index[1:0], csr_wdata[15:0]
//
// One item at a time: accept, run the nibble-serial time compare (which also
// covers the four-step bar divider), see both finish in the run state, then
// commit; a new item is accepted only after the previous one has committed.
// A result waits in the output register; the next item is accepted and
// worked on meanwhile, and its commit waits until the register is taken.
// Synchronous reset restores the register defaults and clears the control
// and strip state, but not the captured item or the result registers.
module rpm_bargraph_shift_light_top
   import rbsl_pkg::*;
#(
   parameter int STRIP_LEDS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_rpm,
   input  logic [31:0] req_now_ms,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_refresh,
   output logic [1:0]  rsp_pattern,
   output logic [4:0]  rsp_bar_count,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   localparam logic [4:0] STRIP_CAP = 5'(STRIP_LEDS);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_COMMIT
   } state_type;

   state_type     state_ff;
   logic [15:0]   max_rpm_ff, shift_rpm_ff, timeout_ms_ff;
   logic [15:0]   rpm_ff;
   logic [31:0]   now_ff;
   logic [31:0]   blink_stamp_ff, blink_stamp_in;
   logic [31:0]   steady_since_ff, steady_since_in;
   logic [4:0]    last_count_ff, last_count_in;
   logic          last_none_ff, last_none_in;
   logic          red_shown_ff, red_shown_in;
   logic          rsp_valid_ff;
   logic          refresh_ff, refresh_in;
   logic [1:0]    pattern_ff, pattern_in;
   logic [4:0]    shown_ff, shown_in;

   logic          accept;
   logic          out_free;
   logic          div_done, tcmp_done;
   logic [4:0]    count;
   rbsl_tchk_type due;
   logic [31:0]   steady_eff;

   assign req_ready  = (state_ff == ST_IDLE);
   assign accept     = req_valid && req_ready;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   // An unset steady mark counts as starting at this item's time.
   assign steady_eff = (steady_since_ff == 32'd0) ? req_now_ms : steady_since_ff;

   rbsl_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (accept),
      .dividend (req_rpm),
      .divisor  (max_rpm_ff),
      .done     (div_done),
      .count    (count)
   );

   rbsl_tcmp u_tcmp (
      .clock   (clock),
      .reset   (reset),
      .start   (accept),
      .now     (req_now_ms),
      .stamp_a (blink_stamp_ff),
      .limit_a (BLINK_MS),
      .stamp_b (steady_eff),
      .limit_b (timeout_ms_ff),
      .done    (tcmp_done),
      .due     (due)
   );

   always_comb begin
      blink_stamp_in  = blink_stamp_ff;
      steady_since_in = steady_since_ff;
      last_count_in   = last_count_ff;
      last_none_in    = last_none_ff;
      red_shown_in    = red_shown_ff;
      refresh_in      = 1'b0;
      pattern_in      = PAT_OFF;
      shown_in        = 5'd0;
      if (rpm_ff >= shift_rpm_ff) begin
         if (due.blink_due) begin
            blink_stamp_in = now_ff;
            refresh_in     = 1'b1;
            red_shown_in   = ~red_shown_ff;
            pattern_in     = red_shown_ff ? PAT_OFF : PAT_RED;
         end
         steady_since_in = now_ff;
      end else if (last_none_ff || count != last_count_ff) begin
         refresh_in      = 1'b1;
         pattern_in      = PAT_BAR;
         shown_in        = (count > STRIP_CAP) ? STRIP_CAP : count;
         red_shown_in    = 1'b0;
         last_count_in   = count;
         last_none_in    = 1'b0;
         steady_since_in = now_ff;
      end else begin
         if (steady_since_ff == 32'd0 || due.idle_due) begin
            steady_since_in = now_ff;
         end
         if (due.idle_due) begin
            refresh_in   = 1'b1;
            red_shown_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         max_rpm_ff      <= MAX_RPM_RESET;
         shift_rpm_ff    <= SHIFT_RPM_RESET;
         timeout_ms_ff   <= TIMEOUT_MS_RESET;
         blink_stamp_ff  <= 32'd0;
         steady_since_ff <= 32'd0;
         last_count_ff   <= 5'd0;
         last_none_ff    <= 1'b1;
         red_shown_ff    <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_MAX_RPM:    max_rpm_ff    <= csr_wdata;
               CSR_SHIFT_RPM:  shift_rpm_ff  <= csr_wdata;
               CSR_TIMEOUT_MS: timeout_ms_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (state_ff == ST_COMMIT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  rpm_ff   <= req_rpm;
                  now_ff   <= req_now_ms;
                  state_ff <= ST_RUN;
               end
            end
            ST_RUN: begin
               if (div_done && tcmp_done) begin
                  state_ff <= ST_COMMIT;
               end
            end
            ST_COMMIT: begin
               if (out_free) begin
                  blink_stamp_ff  <= blink_stamp_in;
                  steady_since_ff <= steady_since_in;
                  last_count_ff   <= last_count_in;
                  last_none_ff    <= last_none_in;
                  red_shown_ff    <= red_shown_in;
                  refresh_ff      <= refresh_in;
                  pattern_ff      <= pattern_in;
                  shown_ff        <= shown_in;
                  state_ff        <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_refresh   = refresh_ff;
   assign rsp_pattern   = pattern_ff;
   assign rsp_bar_count = shown_ff;

endmodule

[design/rbsl_div.sv]
module rbsl_div
   import rbsl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [15:0] dividend,
   input  logic [15:0] divisor,
   output logic        done,
   output logic [4:0]  count
);

   logic [15:0]        rem_ff, rem_in;
   logic [15:0]        div_ff;
   logic [QUOT_W-1:0]  quot_ff, quot_in;
   logic [QUOT_CW-1:0] step_ff;
   logic               busy_ff;
   logic               done_ff;
   logic               sat_ff;
   logic [16:0]        shifted;
   logic               fits;

   // Restoring division of (dividend * 16) by divisor. When dividend is below
   // divisor the first sixteen quotient bits are zero, so only the four steps
   // that shift in the appended zeros are run.
   always_comb begin
      shifted = {rem_ff, 1'b0};
      fits    = shifted >= {1'b0, div_ff};
      rem_in  = fits ? 16'(shifted - {1'b0, div_ff}) : shifted[15:0];
      quot_in = {quot_ff[QUOT_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         sat_ff  <= 1'b0;
         step_ff <= '0;
      end else if (start) begin
         rem_ff  <= dividend;
         div_ff  <= divisor;
         quot_ff <= '0;
         step_ff <= '0;
         if (divisor == 16'd0 || dividend >= divisor) begin
            sat_ff  <= 1'b1;
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end else begin
            sat_ff  <= 1'b0;
            busy_ff <= 1'b1;
            done_ff <= 1'b0;
         end
      end else if (busy_ff) begin
         rem_ff  <= rem_in;
         quot_ff <= quot_in;
         step_ff <= step_ff + 1'b1;
         if (step_ff == QUOT_CW'(QUOT_W - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   assign done  = done_ff;
   assign count = sat_ff ? FULL_BAR : 5'(quot_ff);

endmodule

[design/rbsl_tcmp.sv]
module rbsl_tcmp
   import rbsl_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [TIME_W-1:0] now,
   input  logic [TIME_W-1:0] stamp_a,
   input  logic [15:0]       limit_a,
   input  logic [TIME_W-1:0] stamp_b,
   input  logic [15:0]       limit_b,
   output logic              done,
   output rbsl_tchk_type     due
);

   logic [TIME_W-1:0]   now_ff, a_ff, b_ff;
   logic [15:0]         la_ff, lb_ff;
   logic                bda_ff, bla_ff, bdb_ff, blb_ff;
   logic [DIGIT_CW-1:0] digit_ff;
   logic                busy_ff;
   logic                done_ff;
   logic [DIGIT_W:0]    da, la, db, lb;

   // Per nibble: first (now - stamp) with its own borrow chain, then the
   // difference nibble minus the limit nibble with a second borrow chain.
   // No final borrow from the second chain means the elapsed time is at or
   // above the limit, modulo two to the 32.
   always_comb begin
      da = {1'b0, now_ff[DIGIT_W-1:0]} - {1'b0, a_ff[DIGIT_W-1:0]} - (DIGIT_W+1)'(bda_ff);
      la = {1'b0, da[DIGIT_W-1:0]} - {1'b0, la_ff[DIGIT_W-1:0]} - (DIGIT_W+1)'(bla_ff);
      db = {1'b0, now_ff[DIGIT_W-1:0]} - {1'b0, b_ff[DIGIT_W-1:0]} - (DIGIT_W+1)'(bdb_ff);
      lb = {1'b0, db[DIGIT_W-1:0]} - {1'b0, lb_ff[DIGIT_W-1:0]} - (DIGIT_W+1)'(blb_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         digit_ff <= '0;
      end else if (start) begin
         now_ff   <= now;
         a_ff     <= stamp_a;
         b_ff     <= stamp_b;
         la_ff    <= limit_a;
         lb_ff    <= limit_b;
         bda_ff   <= 1'b0;
         bla_ff   <= 1'b0;
         bdb_ff   <= 1'b0;
         blb_ff   <= 1'b0;
         digit_ff <= '0;
         busy_ff  <= 1'b1;
         done_ff  <= 1'b0;
      end else if (busy_ff) begin
         now_ff   <= now_ff >> DIGIT_W;
         a_ff     <= a_ff >> DIGIT_W;
         b_ff     <= b_ff >> DIGIT_W;
         la_ff    <= la_ff >> DIGIT_W;
         lb_ff    <= lb_ff >> DIGIT_W;
         bda_ff   <= da[DIGIT_W];
         bla_ff   <= la[DIGIT_W];
         bdb_ff   <= db[DIGIT_W];
         blb_ff   <= lb[DIGIT_W];
         digit_ff <= digit_ff + 1'b1;
         if (digit_ff == DIGIT_CW'(DIGITS - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   assign done          = done_ff;
   assign due.blink_due = ~bla_ff;
   assign due.idle_due  = ~blb_ff;

endmodule

[design/rbsl_checker.sv]
module rbsl_checker
   import rbsl_pkg::*;
#(
   parameter int STRIP_LEDS = 16
) (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_refresh,
   input logic [1:0] rsp_pattern,
   input logic [4:0] rsp_bar_count
);

   // A stalled result holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_refresh)
         && $stable(rsp_pattern) && $stable(rsp_bar_count))
      else $error("stalled result changed");

   // A result without a rewrite carries no pattern and no bar.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_refresh |-> rsp_pattern == PAT_OFF && rsp_bar_count == 5'd0)
      else $error("pattern or bar set without refresh");

   // Only the bar pattern lights a bar, and never past the strip.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_pattern == PAT_BAR || rsp_bar_count == 5'd0)
         && rsp_bar_count <= 5'(STRIP_LEDS) && rsp_pattern != 2'd3)
      else $error("bar count out of place");

   // One item is worked on at a time: after an acceptance no new one is taken
   // in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input accepted while busy");

endmodule

bind rpm_bargraph_shift_light_top rbsl_checker #(.STRIP_LEDS(STRIP_LEDS)) u_rbsl_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_refresh   (rsp_refresh),
   .rsp_pattern   (rsp_pattern),
   .rsp_bar_count (rsp_bar_count)
);

[dv/tb.sv]
`timescale 1ns / 1ps

module tb;
   import rbsl_pkg::*;

   localparam int STRIP = 16;
   localparam int unsigned BLINK_PERIOD_MS = 100;
   localparam int unsigned BAR_FULL = 16;
   localparam logic [7:0] NO_BAR = 8'd255;
   localparam int RANDOM_PHASES = 12;
   localparam int PHASE_ITEMS = 155;

   typedef struct packed {
      logic [15:0] rpm;
      logic [31:0] now_ms;
   } sample_type;

   typedef struct packed {
      logic       refresh;
      logic [1:0] pattern;
      logic [4:0] bar_count;
   } strip_upd_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [15:0] req_rpm = '0;
   logic [31:0] req_now_ms = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_refresh;
   logic [1:0]  rsp_pattern;
   logic [4:0]  rsp_bar_count;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   rpm_bargraph_shift_light_top #(.STRIP_LEDS(STRIP)) dut (.*);

   // Register copies and strip state as the block should hold them.
   logic [15:0] cfg_max_rpm = MAX_RPM_RESET;
   logic [15:0] cfg_shift_rpm = SHIFT_RPM_RESET;
   logic [15:0] cfg_timeout_ms = TIMEOUT_MS_RESET;
   logic [31:0] blink_at = '0;
   logic [31:0] steady_at = '0;
   logic [7:0]  drawn_len = NO_BAR;
   logic        red_on = 1'b0;

   sample_type    sample_q[$];
   strip_upd_type strip_upd_q[$];

   logic        req_took = 1'b0;
   logic        idle_on = 1'b1;
   int          send_gap = 0;
   int          stall_left = 0;
   int          n_err = 0;
   int          n_samples = 0;
   int          n_settings = 1;
   int          n_bar = 0;
   int          n_red = 0;
   int          n_blank = 0;
   int          n_quiet = 0;
   logic [15:0] gen_rpm = '0;
   logic [31:0] gen_now = '0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("rpm_bargraph_shift_light_top: mismatch");
      $finish;
   end

   function automatic strip_upd_type strip_update(sample_type s);
      int unsigned len;
      int unsigned shown;
      logic [31:0] dt;
      strip_upd_type u;
      u = '0;
      if (cfg_max_rpm == 0) begin
         len = BAR_FULL;
      end else begin
         len = (32'(s.rpm) * BAR_FULL) / 32'(cfg_max_rpm);
         if (len > BAR_FULL) len = BAR_FULL;
      end
      if (s.rpm >= cfg_shift_rpm) begin
         dt = s.now_ms - blink_at;
         if (dt >= BLINK_PERIOD_MS) begin
            blink_at = s.now_ms;
            u.refresh = 1'b1;
            u.pattern = red_on ? PAT_OFF : PAT_RED;
            red_on = ~red_on;
         end
         steady_at = s.now_ms;
      end else if (len != 32'(drawn_len)) begin
         shown = (len > STRIP) ? STRIP : len;
         u.refresh = 1'b1;
         u.pattern = PAT_BAR;
         u.bar_count = shown[4:0];
         red_on = 1'b0;
         drawn_len = len[7:0];
         steady_at = s.now_ms;
      end else begin
         // A zero stamp means the steady interval has not started yet.
         if (steady_at == 0) steady_at = s.now_ms;
         dt = s.now_ms - steady_at;
         if (dt >= 32'(cfg_timeout_ms)) begin
            u.refresh = 1'b1;
            u.pattern = PAT_OFF;
            red_on = 1'b0;
            steady_at = s.now_ms;
         end
      end
      return u;
   endfunction

   task automatic flag_mismatch(string what, logic [31:0] got_v, logic [31:0] want_v);
      $display("%0t: %s: got %0h, expected %0h", $time, what, got_v, want_v);
      n_err++;
   endtask

   task automatic queue_sample(logic [15:0] r, logic [31:0] t);
      sample_q.push_back('{rpm: r, now_ms: t});
   endtask

   task automatic write_limits(logic [15:0] max_v, logic [15:0] shift_v, logic [15:0] tmo_v);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= CSR_MAX_RPM;
      csr_wdata <= max_v;
      @(negedge clock);
      csr_index <= CSR_SHIFT_RPM;
      csr_wdata <= shift_v;
      @(negedge clock);
      csr_index <= CSR_TIMEOUT_MS;
      csr_wdata <= tmo_v;
      @(negedge clock);
      csr_we <= 1'b0;
      cfg_max_rpm = max_v;
      cfg_shift_rpm = shift_v;
      cfg_timeout_ms = tmo_v;
      n_settings++;
   endtask

   // Holds off the next register write until every item has come back.
   task automatic drain();
      do @(negedge clock);
      while (sample_q.size() != 0 || req_valid || strip_upd_q.size() != 0);
      repeat (12) @(negedge clock);
   endtask

   task automatic random_sample();
      int k;
      int r;
      int hi;
      k = $urandom_range(0, 19);
      if (k < 7) begin
         r = gen_rpm;
      end else if (k < 10) begin
         r = int'(cfg_shift_rpm) + int'($urandom_range(0, 6)) - 3;
      end else if (k < 16) begin
         hi = int'(cfg_max_rpm) + int'(cfg_max_rpm) / 8;
         r = $urandom_range(0, (hi > 65535) ? 65535 : hi);
      end else begin
         r = $urandom_range(0, 65535);
      end
      if (r < 0) r = 0;
      if (r > 65535) r = 65535;
      gen_rpm = r[15:0];
      k = $urandom_range(0, 19);
      if (k < 12) gen_now = gen_now + $urandom_range(0, 150);
      else if (k < 16) gen_now = gen_now + $urandom_range(0, 2 * int'(cfg_timeout_ms) + 20);
      else if (k == 17) gen_now = $urandom;
      else if (k == 18) gen_now = 32'hFFFF_FF00 + $urandom_range(0, 255);
      else if (k == 19) gen_now = $urandom_range(0, 3);
      queue_sample(gen_rpm, gen_now);
   endtask

   // Input side: a new item goes out once the previous one was taken.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_took) begin
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (sample_q.size() > 0) begin
            req_valid <= 1'b1;
            req_rpm <= sample_q[0].rpm;
            req_now_ms <= sample_q[0].now_ms;
            void'(sample_q.pop_front());
            if (idle_on && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 8);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 6) == 0) begin
         stall_left = $urandom_range(0, 7);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      strip_upd_type want;
      if (reset) begin
         req_took <= 1'b0;
      end else begin
         req_took <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            strip_upd_q.push_back(strip_update('{rpm: req_rpm, now_ms: req_now_ms}));
            n_samples++;
         end
         if (rsp_valid && rsp_ready) begin
            if (strip_upd_q.size() == 0) begin
               flag_mismatch("result with no sample pending",
                             32'({rsp_refresh, rsp_pattern, rsp_bar_count}), 32'd0);
            end else begin
               want = strip_upd_q.pop_front();
               if (rsp_refresh !== want.refresh)
                  flag_mismatch("refresh", 32'(rsp_refresh), 32'(want.refresh));
               if (rsp_pattern !== want.pattern)
                  flag_mismatch("pattern", 32'(rsp_pattern), 32'(want.pattern));
               if (rsp_bar_count !== want.bar_count)
                  flag_mismatch("bar_count", 32'(rsp_bar_count), 32'(want.bar_count));
               if (!want.refresh) n_quiet++;
               else if (want.pattern == PAT_BAR) n_bar++;
               else if (want.pattern == PAT_RED) n_red++;
               else n_blank++;
            end
         end
      end
   end

   initial begin
      int mx;
      int sh;
      int tm;
      int hi;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Power-up limits: first bar, timeout from an unset stamp, blink cadence,
      // leaving shift mode at the same length, and time wrapping past zero.
      queue_sample(16'd0, 32'd0);
      queue_sample(16'd0, 32'd10);
      queue_sample(16'd0, 32'd5010);
      queue_sample(16'd3999, 32'd5020);
      queue_sample(16'd6999, 32'd5030);
      queue_sample(16'd7000, 32'd5040);
      queue_sample(16'hFFFF, 32'd5110);
      queue_sample(16'hFFFF, 32'd5140);
      queue_sample(16'd7000, 32'd5240);
      queue_sample(16'd6999, 32'd5250);
      queue_sample(16'd6999, 32'd10240);
      queue_sample(16'd500, 32'd10250);
      queue_sample(16'd500, 32'hFFFF_FFF0);
      queue_sample(16'd500, 32'h0000_0010);
      queue_sample(16'hFFFF, 32'h0000_0020);
      drain();

      // Zero timeout blanks on every unchanged sample.
      write_limits(16'hFFFF, 16'hFFFF, 16'd0);
      queue_sample(16'hFFFE, 32'd100);
      queue_sample(16'hFFFE, 32'd100);
      queue_sample(16'hFFFF, 32'd200);
      queue_sample(16'd0, 32'd200);
      drain();

      // Shift threshold of zero keeps the strip blinking whatever the speed.
      write_limits(16'd1, 16'd0, 16'hFFFF);
      queue_sample(16'd0, 32'd300);
      queue_sample(16'hFFFF, 32'd350);
      drain();

      // Zero full scale saturates the bar.
      write_limits(16'd0, 16'hFFFF, 16'd100);
      queue_sample(16'd12345, 32'd400);
      queue_sample(16'd0, 32'd450);
      queue_sample(16'd0, 32'd500);
      drain();
      gen_now = 32'd500;

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case ($urandom_range(0, 5))
            0: mx = 1;
            1: mx = 65535;
            2: mx = $urandom_range(1, 65535);
            default: mx = $urandom_range(2000, 12000);
         endcase
         hi = mx + mx / 4;
         case ($urandom_range(0, 4))
            0: sh = 0;
            1: sh = 65535;
            2: sh = $urandom_range(0, 65535);
            default: sh = $urandom_range(mx / 2, (hi > 65535) ? 65535 : hi);
         endcase
         case ($urandom_range(0, 5))
            0: tm = 0;
            1: tm = 65535;
            2: tm = $urandom_range(0, 65535);
            default: tm = $urandom_range(1, 400);
         endcase
         write_limits(mx[15:0], sh[15:0], tm[15:0]);
         idle_on = (p != RANDOM_PHASES - 1) && (p % 3 != 2);
         for (int i = 0; i < PHASE_ITEMS; i++) random_sample();
         drain();
      end

      repeat (20) @(negedge clock);
      $display("Checked %0d samples across %0d limit settings.", n_samples, n_settings);
      $display("Strip rewrites: %0d bar, %0d red, %0d blank; %0d samples left it alone.",
               n_bar, n_red, n_blank, n_quiet);
      if (n_err == 0) begin
         $display("rpm_bargraph_shift_light_top: match");
      end else begin
         $display("rpm_bargraph_shift_light_top: mismatch");
      end
      $finish;
   end

endmodule
